// ===== hdl/lls_pkg.sv =====
// Package for the least loaded slot selector: transaction structs, command
// and status codes, field widths, and the controller/datapath link structs.
// No dependencies.
`default_nettype none

package lls_pkg;

  localparam int CMD_W  = 3;
  localparam int SLOT_W = 6;
  localparam int KIND_W = 4;
  localparam int PRI_W  = 8;
  localparam int CNT_W  = 16;
  localparam int MAXC_W = 17;
  localparam int POS_W  = 7;
  localparam int LIM_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SETL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ADD_BUSY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEL_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] entry_type;
    logic [PRI_W-1:0]  entry_priority;
    logic [CNT_W-1:0]  entry_count;
    logic [MAXC_W-1:0] max_count;
    logic [PRI_W-1:0]  min_priority;
    logic              use_start;
    logic [POS_W-1:0]  start_pos;
    logic              use_stop;
    logic [POS_W-1:0]  stop_pos;
  } lls_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [SLOT_W-1:0] found_slot;
    logic [POS_W-1:0]  next_start;
    logic [LIM_W-1:0]  limit_out;
  } lls_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic do_add;
    logic do_del;
    logic do_setl;
    logic do_clear;
    logic find_init;
    logic scan_step;
    logic shrink_step;
  } lls_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             slot_valid;
    logic             slot_is_top;
    logic             lim_zero;
    logic             scan_end;
    logic             shrink_end;
  } lls_sts_t;

endpackage

`default_nettype wire

// ===== hdl/least_loaded_slot_selector.sv =====
// Top level of the least loaded slot selector: joins the sequencer and the
// datapath. Depends on lls_pkg, lls_ctrl and lls_dp.
//
// Usage:
//   A command transaction on in_data is taken at a rising edge with start
//   high and busy low. Exactly one result transaction follows on out_data,
//   marked by out_valid for a single cycle; the receiver cannot stall it and
//   must take it in that cycle.
//   Commands: add, delete, set load count, find, reset all.
// Sequence from the accept edge to the out_valid cycle:
//   add, set load count, reset all, unused codes: execute, then done.
//   delete: as add; when the top slot is removed, a shrink state walks the
//     empty slots below it to shrink the limit (one valid bit per cycle).
//   find: execute, then done with a zero limit, else a scan of at most
//     SLOTS slots between; kind/priority and load memories give one entry
//     per cycle through a single registered read port, setting the scan rate.
//   busy drops in the out_valid cycle, so the next command can be taken
//   while the current result is shown.
// Reset (rst_n low, synchronous): all valid marks and the limit clear and the
//   sequencer goes idle; table memories keep stale contents that cannot be
//   reached until an add rewrites them.
`default_nettype none

module least_loaded_slot_selector #(
  parameter int SLOTS = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  lls_pkg::lls_in_t  in_data,
  output logic              out_valid,
  output lls_pkg::lls_out_t out_data
);
  import lls_pkg::*;

  lls_ctl_t ctl;
  lls_sts_t sts;

  // sequencer: owns start/busy and the result strobe
  lls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  // datapath: tables, limit, scan and result registers
  lls_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/lls_ctrl.sv =====
// Sequencer for the least loaded slot selector: decodes the latched command
// and steps the datapath through add, delete/shrink, scan and result cycles.
// Depends on lls_pkg.
`default_nettype none

module lls_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  output logic              out_valid,
  input  lls_pkg::lls_sts_t sts,
  output lls_pkg::lls_ctl_t ctl
);
  import lls_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SHRINK = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign busy      = !((state_r == S_IDLE) || (state_r == S_DONE));
  assign accept    = start && !busy;
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    ctl          = '0;
    ctl.load_req = accept;
    state_nxt    = state_r;
    case (state_r)
      S_IDLE, S_DONE: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (sts.cmd)
          CMD_ADD: begin
            ctl.do_add = 1'b1;
          end
          CMD_DEL: begin
            ctl.do_del = 1'b1;
            if (sts.slot_valid && sts.slot_is_top) begin
              state_nxt = S_SHRINK;
            end
          end
          CMD_SETL: begin
            ctl.do_setl = 1'b1;
          end
          CMD_FIND: begin
            ctl.find_init = 1'b1;
            if (!sts.lim_zero) begin
              state_nxt = S_SCAN;
            end
          end
          CMD_CLEAR: begin
            ctl.do_clear = 1'b1;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SHRINK: begin
        if (sts.shrink_end) begin
          state_nxt = S_DONE;
        end else begin
          ctl.shrink_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_DONE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lls_dp.sv =====
// Datapath for the least loaded slot selector: valid bits, slot limit, the
// kind/priority and load memories, scan position counters and best tracker.
// Depends on lls_pkg.
`default_nettype none

module lls_dp #(
  parameter int SLOTS = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  lls_pkg::lls_in_t  in_data,
  input  lls_pkg::lls_ctl_t ctl,
  output lls_pkg::lls_sts_t sts,
  output lls_pkg::lls_out_t out_data
);
  import lls_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  lls_in_t req_r;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [LIM_W-1:0] limit_r, limit_nxt;

  logic [KIND_W+PRI_W-1:0] kp_mem   [SLOTS];
  logic [CNT_W-1:0]        load_mem [SLOTS];

  logic [KIND_W+PRI_W-1:0] rd_kp_r;
  logic [CNT_W-1:0]        rd_load_r;
  logic                    rd_valid_r;
  logic                    rd_vld_r;

  logic [POS_W-1:0]  pos_r, stop_r, pnext, pos_init, stop_init;
  logic [LIM_W-1:0]  step_r, lim_m1, slot_p1, slot_ext;
  logic              have_r;
  logic [SLOT_W-1:0] best_r;
  logic [PRI_W-1:0]  best_pri_r;
  logic [CNT_W-1:0]  best_load_r;
  logic [STAT_W-1:0] status_r;

  logic [AW-1:0]     slot_idx, scan_idx;
  logic              slot_ok, slot_valid, add_ok, is_find;
  logic [KIND_W-1:0] rd_kind;
  logic [PRI_W-1:0]  rd_pri;
  logic              qual, better, take;

  // slot decode
  assign slot_idx   = AW'(req_r.slot);
  assign slot_ok    = (32'(req_r.slot) < SLOTS);
  assign slot_valid = slot_ok && valid_r[slot_idx];
  assign add_ok     = slot_ok && !valid_r[slot_idx];
  assign slot_ext   = {1'b0, req_r.slot};
  assign slot_p1    = slot_ext + LIM_W'(1);
  assign lim_m1     = limit_r - LIM_W'(1);

  // scan position
  assign pnext     = (pos_r + POS_W'(1) == limit_r) ? '0 : pos_r + POS_W'(1);
  assign scan_idx  = AW'(pnext);
  assign pos_init  = (req_r.use_start && (req_r.start_pos < limit_r)) ?
                     req_r.start_pos : lim_m1;
  assign stop_init = (req_r.stop_pos >= limit_r) ? lim_m1 : req_r.stop_pos;

  // candidate compare on registered read data
  assign rd_kind = rd_kp_r[KIND_W+PRI_W-1:PRI_W];
  assign rd_pri  = rd_kp_r[PRI_W-1:0];
  assign qual    = rd_valid_r && (rd_kind == req_r.entry_type) &&
                   ({1'b0, rd_load_r} < req_r.max_count) &&
                   (req_r.use_stop ? (rd_pri == req_r.min_priority)
                                   : (rd_pri >= req_r.min_priority));
  assign better  = !have_r || (rd_pri < best_pri_r) ||
                   ((rd_pri == best_pri_r) && (rd_load_r < best_load_r));
  assign take    = rd_vld_r && qual && better;

  assign sts.cmd         = req_r.command;
  assign sts.slot_valid  = slot_valid;
  assign sts.slot_is_top = (slot_p1 == limit_r);
  assign sts.lim_zero    = (limit_r == '0);
  assign sts.scan_end    = (step_r == limit_r) ||
                           (req_r.use_stop && (pnext == stop_r));
  assign sts.shrink_end  = (limit_r == '0) || valid_r[AW'(lim_m1)];

  always_comb begin
    valid_nxt = valid_r;
    limit_nxt = limit_r;
    if (ctl.do_add && add_ok) begin
      valid_nxt[slot_idx] = 1'b1;
      if (limit_r <= slot_ext) begin
        limit_nxt = slot_p1;
      end
    end
    if (ctl.do_del && slot_valid) begin
      valid_nxt[slot_idx] = 1'b0;
      if (slot_p1 == limit_r) begin
        limit_nxt = slot_ext;
      end
    end
    if (ctl.shrink_step) begin
      limit_nxt = lim_m1;
    end
    if (ctl.do_clear) begin
      valid_nxt = '0;
      limit_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      limit_r  <= '0;
      rd_vld_r <= 1'b0;
      have_r   <= 1'b0;
      status_r <= ST_OK;
    end else begin
      valid_r  <= valid_nxt;
      limit_r  <= limit_nxt;
      rd_vld_r <= ctl.scan_step;
      if (ctl.load_req) begin
        have_r   <= 1'b0;
        status_r <= ST_OK;
      end else begin
        if (take) begin
          have_r <= 1'b1;
        end
        if (ctl.do_add && !add_ok) begin
          status_r <= ST_ADD_BUSY;
        end else if (ctl.do_del && !slot_valid) begin
          status_r <= ST_DEL_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_r  <= in_data;
      best_r <= '0;
    end else if (take) begin
      best_r      <= SLOT_W'(pos_r);
      best_pri_r  <= rd_pri;
      best_load_r <= rd_load_r;
    end
    if (ctl.find_init) begin
      pos_r  <= pos_init;
      stop_r <= stop_init;
      step_r <= '0;
    end else if (ctl.scan_step) begin
      pos_r  <= pnext;
      step_r <= step_r + LIM_W'(1);
    end
  end

  // table memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (ctl.do_add && add_ok) begin
      kp_mem[slot_idx]   <= {req_r.entry_type, req_r.entry_priority};
      load_mem[slot_idx] <= '0;
    end else if (ctl.do_setl && slot_ok) begin
      load_mem[slot_idx] <= req_r.entry_count;
    end
    if (ctl.scan_step) begin
      rd_kp_r    <= kp_mem[scan_idx];
      rd_load_r  <= load_mem[scan_idx];
      rd_valid_r <= valid_r[scan_idx];
    end
  end

  assign is_find             = (req_r.command == CMD_FIND);
  assign out_data.status     = status_r;
  assign out_data.found      = is_find && have_r;
  assign out_data.found_slot = best_r;
  assign out_data.next_start = !is_find ? '0 :
                               (have_r && req_r.use_start) ? {1'b0, best_r} :
                               req_r.start_pos;
  assign out_data.limit_out  = limit_r;

endmodule

`default_nettype wire

// ===== hdl/lls_checker.sv =====
// Port-level checks for the least loaded slot selector, attached by bind.
// Depends on lls_pkg and least_loaded_slot_selector.
`default_nettype none

module lls_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               start,
  input wire               busy,
  input wire               out_valid,
  input lls_pkg::lls_out_t out_data
);
  import lls_pkg::*;

  // a result strobe lasts one cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // an accepted command keeps the block busy for its execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("block not busy after accepted transaction");

  // a found slot lies below the limit
  a_found_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |->
      ({1'b0, out_data.found_slot} < out_data.limit_out))
    else $error("found slot at or above limit");

  // an error status never comes with a hit
  a_status_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> !out_data.found)
    else $error("found set with error status");

  // limit never exceeds the addressable slot range
  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.limit_out <= LIM_W'(64)))
    else $error("limit out of range");

endmodule

bind least_loaded_slot_selector lls_checker u_lls_checker (.*);

`default_nettype wire

// ===== tb/sv/least_loaded_slot_selector_test.sv =====
// Self-checking testbench for least_loaded_slot_selector: directed and random
// command transactions, checked against a cycle-free predictor of the slot table.
// Depends on lls_pkg and the least_loaded_slot_selector RTL.

module least_loaded_slot_selector_test;
  import lls_pkg::*;

  localparam int SLOTS          = 64;
  localparam int ITEM_TARGET    = 950;
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles
  localparam int TAIL_CYCLES    = 80;    // extra cycles run after the last result is checked
  localparam int MAX_PRINTS     = 40;
  localparam logic [CMD_W-1:0] CMD_LAST = '1;

  // One queued command plus the idle time and drain pause that follow it.
  typedef struct packed {
    lls_in_t    cmd;
    logic [7:0] idle_after;
    logic       drain_after;
  } pending_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  lls_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  lls_out_t out_data;

  least_loaded_slot_selector #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the slot table.  The kind, priority and
  // load memories are only consulted for live slots, so their unwritten
  // contents never matter.
  // ---------------------------------------------------------------------------
  logic [SLOTS-1:0]  live_slots = '0;
  logic [KIND_W-1:0] kind_mem [SLOTS];
  logic [PRI_W-1:0]  prio_mem [SLOTS];
  logic [CNT_W-1:0]  load_mem [SLOTS];
  int unsigned       slot_limit = 0;

  pending_t queued_commands[$];
  lls_out_t predicted_results[$];
  int       n_queued = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       n_errors = 0;

  // Applies one command to the table copy and returns the result it causes.
  function automatic lls_out_t apply_command(input lls_in_t c);
    lls_out_t    r;
    int unsigned lim;
    int unsigned pos;
    int unsigned stop_at;
    int unsigned best;
    int unsigned top;
    logic        have;
    logic        ok;
    r = '0;
    case (c.command)
      CMD_ADD: begin
        if (live_slots[c.slot]) begin
          r.status = ST_ADD_BUSY;
        end else begin
          live_slots[c.slot] = 1'b1;
          kind_mem[c.slot] = c.entry_type;
          prio_mem[c.slot] = c.entry_priority;
          load_mem[c.slot] = '0;
          if (slot_limit <= c.slot) slot_limit = int'(c.slot) + 1;
        end
      end
      CMD_DEL: begin
        if (!live_slots[c.slot]) begin
          r.status = ST_DEL_EMPTY;
        end else begin
          live_slots[c.slot] = 1'b0;
          // removing the top slot walks the limit down past empty slots
          if (int'(c.slot) + 1 == slot_limit) begin
            top = slot_limit;
            while (top > 0 && !live_slots[top-1]) top--;
            slot_limit = top;
          end
        end
      end
      CMD_SETL: load_mem[c.slot] = c.entry_count;
      CMD_FIND: begin
        lim = slot_limit;
        r.next_start = c.start_pos;
        if (lim != 0) begin
          // pos is the position just before the next one scanned
          pos = (c.use_start && c.start_pos < lim) ? c.start_pos : lim - 1;
          stop_at = (c.stop_pos >= lim) ? lim - 1 : c.stop_pos;
          have = 1'b0;
          best = 0;
          for (int j = 0; j < lim; j++) begin
            pos = (pos + 1 == lim) ? 0 : pos + 1;
            if (c.use_stop && pos == stop_at) break;
            ok = live_slots[pos] && kind_mem[pos] == c.entry_type &&
                 {1'b0, load_mem[pos]} < c.max_count &&
                 (c.use_stop ? prio_mem[pos] == c.min_priority
                             : prio_mem[pos] >= c.min_priority);
            // lower priority wins, then lower load; ties keep the earlier one
            if (ok && (!have || prio_mem[pos] < prio_mem[best] ||
                       (prio_mem[pos] == prio_mem[best] &&
                        load_mem[pos] < load_mem[best]))) begin
              have = 1'b1;
              best = pos;
            end
          end
          if (have) begin
            r.found = 1'b1;
            r.found_slot = SLOT_W'(best);
            if (c.use_start) r.next_start = POS_W'(best);
          end
        end
      end
      CMD_CLEAR: begin
        live_slots = '0;
        slot_limit = 0;
      end
      default: ;  // spare codes change nothing
    endcase
    r.limit_out = LIM_W'(slot_limit);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0d expected %0d",
               n_results, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic lls_in_t command_word(
    input logic [CMD_W-1:0]  op,
    input logic [SLOT_W-1:0] slot = '0,
    input logic [KIND_W-1:0] kind = '0,
    input logic [PRI_W-1:0]  pri = '0,
    input logic [CNT_W-1:0]  cnt = '0,
    input logic [MAXC_W-1:0] maxc = '0,
    input logic [PRI_W-1:0]  minp = '0,
    input logic              use_start = 1'b0,
    input logic [POS_W-1:0]  start_pos = '0,
    input logic              use_stop = 1'b0,
    input logic [POS_W-1:0]  stop_pos = '0);
    lls_in_t c;
    c.command        = op;
    c.slot           = slot;
    c.entry_type     = kind;
    c.entry_priority = pri;
    c.entry_count    = cnt;
    c.max_count      = maxc;
    c.min_priority   = minp;
    c.use_start      = use_start;
    c.start_pos      = start_pos;
    c.use_stop       = use_stop;
    c.stop_pos       = stop_pos;
    return c;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.  One stretch
  // of the random part runs with no gaps at all.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (n_queued >= 400 && n_queued < 560) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic queue_item(input lls_in_t c, input logic drain = 1'b0);
    pending_t p;
    p.cmd = c;
    p.idle_after = 8'(idle_len());
    p.drain_after = drain;
    queued_commands.push_back(p);
    n_queued++;
  endtask

  // Random command: fields start fully random, then the ones that steer the
  // table are pulled toward a small working set so finds have real matches.
  function automatic lls_in_t random_command();
    lls_in_t     c;
    int unsigned roll;
    c.command        = CMD_W'($urandom);
    c.slot           = SLOT_W'($urandom);
    c.entry_type     = KIND_W'($urandom);
    c.entry_priority = PRI_W'($urandom);
    c.entry_count    = CNT_W'($urandom);
    c.max_count      = MAXC_W'($urandom_range(0, 65536));
    c.min_priority   = PRI_W'($urandom);
    c.use_start      = 1'($urandom);
    c.start_pos      = POS_W'($urandom);
    c.use_stop       = ($urandom_range(0, 3) == 0);
    c.stop_pos       = POS_W'($urandom);

    roll = $urandom_range(0, 99);
    if (roll < 24)      c.command = CMD_ADD;
    else if (roll < 36) c.command = CMD_DEL;
    else if (roll < 50) c.command = CMD_SETL;
    else if (roll < 95) c.command = CMD_FIND;
    else if (roll < 97) c.command = CMD_CLEAR;
    else c.command = CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, int'(CMD_LAST)));

    if ($urandom_range(0, 99) < 80) c.slot = SLOT_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 85) c.entry_type = KIND_W'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 70) c.entry_priority = PRI_W'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 0) c.entry_count = CNT_W'($urandom_range(0, 20));
    roll = $urandom_range(0, 99);
    if (roll < 40)      c.max_count = MAXC_W'(65536);
    else if (roll < 80) c.max_count = MAXC_W'($urandom_range(0, 30));
    roll = $urandom_range(0, 99);
    if (roll < 60)      c.min_priority = '0;
    else if (roll < 90) c.min_priority = PRI_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 70) c.start_pos = POS_W'($urandom_range(0, 20));
    if ($urandom_range(0, 99) < 70) c.stop_pos = POS_W'($urandom_range(0, 20));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued transaction, holds it while busy, and
  // predicts its result at the edge where it is taken.  Gaps and drain pauses
  // are only inserted between transactions, never while one is offered.
  // ---------------------------------------------------------------------------
  pending_t    next_cmd;
  int unsigned idle_left = 0;
  logic        hold_for_drain = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      idle_left = 0;
      hold_for_drain = 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(apply_command(in_data));
        n_accepted++;
      end
      if (!(start && busy)) begin
        if (idle_left != 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (hold_for_drain && predicted_results.size() != 0) begin
          start <= 1'b0;  // wait for every outstanding result
        end else if (queued_commands.size() != 0) begin
          next_cmd = queued_commands.pop_front();
          in_data <= next_cmd.cmd;
          start <= 1'b1;
          idle_left = next_cmd.idle_after;
          hold_for_drain = next_cmd.drain_after;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every out_valid cycle carries one result transaction, matched in
  // order against the oldest prediction.
  // ---------------------------------------------------------------------------
  lls_out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        flag_mismatch("result with no command outstanding", 1, 0);
      end else begin
        want = predicted_results.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch("status", out_data.status, want.status);
        if (out_data.found !== want.found)
          flag_mismatch("found", out_data.found, want.found);
        if (out_data.found_slot !== want.found_slot)
          flag_mismatch("found_slot", out_data.found_slot, want.found_slot);
        if (out_data.next_start !== want.next_start)
          flag_mismatch("next_start", out_data.next_start, want.next_start);
        if (out_data.limit_out !== want.limit_out)
          flag_mismatch("limit_out", out_data.limit_out, want.limit_out);
      end
      n_results++;
    end
  end

  // Watchdog: ends the run after too many cycles with no transaction moving.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("least_loaded_slot_selector_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hi;
    lls_in_t     c;

    // Directed: empty table, empty-slot corner cases, field extremes, scan
    // start and stop handling, limit shrink, spare codes and reset all.
    queue_item(command_word(CMD_FIND, 0, 0, 0, 0, 17'd65536));      // zero limit
    queue_item(command_word(CMD_DEL, 0));                           // delete empty
    queue_item(command_word(CMD_SETL, 5, 0, 0, 16'hFFFF));          // load on empty
    queue_item(command_word(CMD_ADD, 5, 3, 7));                     // add clears it
    queue_item(command_word(CMD_FIND, 0, 3, 0, 0, 17'd1));
    queue_item(command_word(CMD_ADD, 0, 0, 0));
    queue_item(command_word(CMD_ADD, 63, 15, 255));
    queue_item(command_word(CMD_ADD, 0, 15, 1));                    // slot busy
    queue_item(command_word(CMD_SETL, 63, 0, 0, 16'hFFFF));
    queue_item(command_word(CMD_FIND, 0, 15, 0, 0, 17'd65536, 255));
    queue_item(command_word(CMD_FIND, 0, 15, 0, 0, 17'd65535, 255)); // load too high
    queue_item(command_word(CMD_ADD, 42, 15, 255));
    queue_item(command_word(CMD_FIND, 0, 15, 0, 0, 17'd65536, 255, 1, 42));
    queue_item(command_word(CMD_FIND, 0, 15, 0, 0, 17'd65536, 255, 1, 127));
    // stop position past the limit clamps to the top slot
    queue_item(command_word(CMD_FIND, 0, 15, 0, 0, 17'd65536, 255, 1, 42, 1, 127));
    queue_item(command_word(CMD_FIND, 0, 0, 0, 0, 17'd65536, 0, 0, 0, 1, 0));
    queue_item(command_word(CMD_FIND, 0, 0, 0, 0, 17'd65536, 0, 0, 0, 1, 5));
    queue_item(command_word(CMD_DEL, 63));                          // shrink walk
    queue_item(command_word(CMD_DEL, 42));
    queue_item(command_word(CMD_DEL, 42));
    for (int op = int'(CMD_CLEAR) + 1; op <= int'(CMD_LAST); op++)
      queue_item(command_word(CMD_W'(op), 1, 1, 1, 1, 17'd1, 0, 1, 3, 0, 0));
    queue_item(command_word(CMD_CLEAR));
    queue_item(command_word(CMD_FIND, 0, 0, 0, 0, 17'd65536, 0, 1, 0), 1'b1);

    // Random part.  Now and then an add/find/delete triple on a high slot
    // makes the limit jump up and then walk back down.
    while (n_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 8) begin
        hi = $urandom_range(16, SLOTS - 1);
        queue_item(command_word(CMD_ADD, SLOT_W'(hi), KIND_W'($urandom_range(0, 3)),
                                PRI_W'($urandom_range(0, 7))));
        c = random_command();
        c.command = CMD_FIND;
        queue_item(c);
        queue_item(command_word(CMD_DEL, SLOT_W'(hi)));
      end else begin
        queue_item(random_command(), (n_queued % 300) == 299);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_queued || predicted_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("least_loaded_slot_selector_test: PASS");
    end else begin
      $display("least_loaded_slot_selector_test: FAIL");
    end
    $finish;
  end

endmodule
